FILE: sv/uart_rx_sampler_with_ring_buffer_assert.svh
// Assertion macros used by the port-level checker of the UART receiver block.
`ifndef UART_RX_SAMPLER_WITH_RING_BUFFER_ASSERT_SVH
`define UART_RX_SAMPLER_WITH_RING_BUFFER_ASSERT_SVH

// Clocked assertion that is switched off while reset is active.
`define URXRB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define URXRB_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/urxrb_pkg.sv
// Package with types and constants of the UART receiver with byte buffer.
`default_nettype none

package urxrb_pkg;

	localparam int BUFFER_DEPTH = 16;

	localparam int HALF_W = 16;
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 18;
	localparam int IDX_W  = 1;

	localparam logic [HALF_W-1:0] HALF_BIT_TICKS_RST = 16'd52;
	localparam logic [BYTE_W-1:0] SELECT_BYTE_RST    = 8'd108;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_HALF_BIT_TICKS = 1'd0;
	localparam logic [IDX_W-1:0] REG_SELECT_BYTE    = 1'd1;

	// Request codes.
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic req_type;
		logic rx_level;
	} in_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_byte;
		logic              read_valid;
		logic              available;
		logic              byte_stored;
		logic              opamp_level;
		logic              led_level;
	} out_word_t;

	// Buffer write request from the receiver.
	typedef struct packed {
		logic              en;
		logic [BYTE_W-1:0] data;
	} buf_wr_t;

	// Receiver status after the current word.
	typedef struct packed {
		logic stored;
		logic opamp;
		logic led;
	} rx_stat_t;

endpackage

`default_nettype wire

FILE: sv/urxrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module urxrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/urxrb_rx.sv
// Serial line receiver: start detection, bit timing, shift register and config registers.
`default_nettype none

module urxrb_rx (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [urxrb_pkg::IDX_W-1:0]   wr_index,
	input  wire logic [urxrb_pkg::HALF_W-1:0]  wr_data,
	input  wire logic                          tick,
	input  wire logic                          level,
	output urxrb_pkg::buf_wr_t                 buf_wr,
	output urxrb_pkg::rx_stat_t                stat
);

	logic [urxrb_pkg::HALF_W-1:0] half_q;
	logic [urxrb_pkg::BYTE_W-1:0] sel_q;
	logic                         recv_q;
	logic [urxrb_pkg::CNT_W-1:0]  cnt_q;
	logic [2:0]                   bit_q;
	logic [urxrb_pkg::BYTE_W-1:0] shift_q;
	logic                         prev_q;
	logic                         opamp_q;
	logic                         led_q;

	logic [urxrb_pkg::CNT_W-1:0]  target;
	logic [urxrb_pkg::CNT_W-1:0]  cnt_inc;
	logic                         hit;
	logic                         start;
	logic                         done;
	logic [urxrb_pkg::BYTE_W-1:0] byte_full;
	logic                         opamp_n;

	always_comb begin
		if (bit_q == 3'd0) begin
			target = {2'b00, half_q} + {1'b0, half_q, 1'b0};
		end else begin
			target = {1'b0, half_q, 1'b0};
		end
		cnt_inc   = cnt_q + 1'b1;
		hit       = cnt_inc >= target;
		start     = tick && !recv_q && prev_q && !level;
		done      = tick && recv_q && hit && (bit_q == 3'd7);
		byte_full = {level, shift_q[6:0]};
		opamp_n   = done ? (byte_full == sel_q) : opamp_q;
	end

	assign buf_wr.en   = done;
	assign buf_wr.data = byte_full;
	assign stat.stored = done;
	assign stat.opamp  = opamp_n;
	assign stat.led    = led_q ^ start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= urxrb_pkg::HALF_BIT_TICKS_RST;
			sel_q  <= urxrb_pkg::SELECT_BYTE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				urxrb_pkg::REG_HALF_BIT_TICKS: half_q <= wr_data;
				urxrb_pkg::REG_SELECT_BYTE:    sel_q  <= wr_data[urxrb_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q  <= 1'b0;
			cnt_q   <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			prev_q  <= 1'b1;
			opamp_q <= 1'b0;
			led_q   <= 1'b0;
		end else if (tick) begin
			prev_q <= level;
			if (!recv_q) begin
				if (start) begin
					recv_q  <= 1'b1;
					cnt_q   <= '0;
					bit_q   <= '0;
					shift_q <= '0;
					led_q   <= !led_q;
				end
			end else if (hit) begin
				cnt_q <= '0;
				if (level) begin
					shift_q[bit_q] <= 1'b1;
				end
				if (bit_q == 3'd7) begin
					recv_q  <= 1'b0;
					bit_q   <= '0;
					opamp_q <= opamp_n;
				end else begin
					bit_q <= bit_q + 3'd1;
				end
			end else begin
				cnt_q <= cnt_inc;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/urxrb_fifo.sv
// Ring buffer: write and read pointers around the byte RAM.
`default_nettype none

module urxrb_fifo #(
	parameter int BUFFER_DEPTH = urxrb_pkg::BUFFER_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire urxrb_pkg::buf_wr_t            buf_wr,
	input  wire logic                          rd_req,
	output logic                               pop,
	output logic                               avail,
	output logic [urxrb_pkg::BYTE_W-1:0]       rdata
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(BUFFER_DEPTH - 1);

	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW-1:0] wp_n;
	logic [AW-1:0] rp_n;

	always_comb begin
		pop  = rd_req && (wp_q != rp_q);
		wp_n = wp_q;
		rp_n = rp_q;
		if (buf_wr.en) begin
			wp_n = (wp_q == LAST) ? '0 : wp_q + 1'b1;
		end
		if (pop) begin
			rp_n = (rp_q == LAST) ? '0 : rp_q + 1'b1;
		end
		avail = wp_n != rp_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			wp_q <= wp_n;
			rp_q <= rp_n;
		end
	end

	// A read and a write never come in the same word, and a popped entry was
	// written at an earlier edge, so the registered read needs no bypass.
	urxrb_ram #(
		.WIDTH (urxrb_pkg::BYTE_W),
		.DEPTH (BUFFER_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (buf_wr.en),
		.waddr (wp_q),
		.wdata (buf_wr.data),
		.re    (pop),
		.raddr (rp_q),
		.rdata (rdata)
	);

endmodule

`default_nettype wire

FILE: sv/uart_rx_sampler_with_ring_buffer.sv
// Top level of the UART receiver with byte ring buffer and output register.
//
//   channel  direction  handshake           word
//   in       input      in_valid/in_stall   in_word_t  (req_type, rx_level)
//   out      output     out_valid/out_stall out_word_t (read_byte .. led_level)
//   config   input      wr_en               wr_index, wr_data
//
// One word is accepted every cycle while in_stall is low; the receiver state
// update and the single write or read of the buffer RAM are registered.
// A result waits in stage 1 (stat_s1, avail_s1) and then enters the output register.
// Reset clears the pointers and receiver state at once; the RAM is not cleared.
// Stalls on out back up through the stage after the RAM into in_stall.
`default_nettype none

module uart_rx_sampler_with_ring_buffer #(
	parameter int BUFFER_DEPTH = urxrb_pkg::BUFFER_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire urxrb_pkg::in_word_t           in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output urxrb_pkg::out_word_t               out_data,
	input  wire logic                          wr_en,
	input  wire logic [urxrb_pkg::IDX_W-1:0]   wr_index,
	input  wire logic [urxrb_pkg::HALF_W-1:0]  wr_data
);

	logic                         accept;
	logic                         tick;
	logic                         rd_req;
	urxrb_pkg::buf_wr_t           buf_wr;
	urxrb_pkg::rx_stat_t          stat;
	logic                         pop;
	logic                         avail;
	logic [urxrb_pkg::BYTE_W-1:0] rdata;

	logic                         valid_s1;
	logic                         rvalid_s1;
	logic                         avail_s1;
	urxrb_pkg::rx_stat_t          stat_s1;
	logic                         adv_s1;
	logic                         out_valid_q;
	urxrb_pkg::out_word_t         out_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;
	assign tick     = accept && (in_data.req_type == urxrb_pkg::REQ_TICK);
	assign rd_req   = accept && (in_data.req_type == urxrb_pkg::REQ_READ);

	urxrb_rx u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.tick     (tick),
		.level    (in_data.rx_level),
		.buf_wr   (buf_wr),
		.stat     (stat)
	);

	urxrb_fifo #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.buf_wr (buf_wr),
		.rd_req (rd_req),
		.pop    (pop),
		.avail  (avail),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rvalid_s1 <= pop;
			avail_s1  <= avail;
			stat_s1   <= stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// The RAM read data holds until the next pop, so it is still good here.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q.read_byte   <= rvalid_s1 ? rdata : '0;
			out_q.read_valid  <= rvalid_s1;
			out_q.available   <= avail_s1;
			out_q.byte_stored <= stat_s1.stored;
			out_q.opamp_level <= stat_s1.opamp;
			out_q.led_level   <= stat_s1.led;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

FILE: sv/urxrb_checker.sv
// Port-level checker for the UART receiver top level, with its bind statement.
`default_nettype none

`include "uart_rx_sampler_with_ring_buffer_assert.svh"

module urxrb_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire urxrb_pkg::in_word_t           in_data,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire urxrb_pkg::out_word_t          out_data,
	input wire logic                          wr_en,
	input wire logic [urxrb_pkg::IDX_W-1:0]   wr_index,
	input wire logic [urxrb_pkg::HALF_W-1:0]  wr_data
);

	`URXRB_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled output word changed")

	`URXRB_ASSERT(a_empty_read_zero, out_valid && !out_data.read_valid |-> out_data.read_byte == '0, "read byte nonzero without a pop")

	`URXRB_ASSERT(a_pop_not_stored, out_valid && out_data.read_valid |-> !out_data.byte_stored, "pop and store in one result")

	`URXRB_ASSERT_RST(a_reset_idle, !arst_n |-> !out_valid, "output valid during reset")

endmodule

bind uart_rx_sampler_with_ring_buffer urxrb_checker u_chk (.*);

`default_nettype wire

FILE: tb/uart_rx_result_checker.sv
// Checker that predicts and compares every result word of the UART receiver block.
module uart_rx_result_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  urxrb_pkg::in_word_t              in_data,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  urxrb_pkg::out_word_t             out_data,
	input  logic                             wr_en,
	input  logic [urxrb_pkg::IDX_W-1:0]      wr_index,
	input  logic [urxrb_pkg::HALF_W-1:0]     wr_data,
	output int                               mismatches,
	output int                               pending
);
	import urxrb_pkg::*;

	localparam int PTR_W = $clog2(BUFFER_DEPTH);
	localparam int REPORT_MAX = 10;

	logic [HALF_W-1:0] half_ticks;
	logic [BYTE_W-1:0] match_byte;

	logic              rx_busy;
	logic [CNT_W-1:0]  tick_cnt;
	logic [2:0]        bit_pos;
	logic [BYTE_W-1:0] shift_reg;
	logic              last_level;
	logic [BYTE_W-1:0] ring [BUFFER_DEPTH];
	logic [PTR_W-1:0]  wr_ptr;
	logic [PTR_W-1:0]  rd_ptr;
	logic              opamp_q;
	logic              led_q;

	out_word_t expected_words[$];
	out_word_t want_word;

	function out_word_t predict_uart_word(in_word_t w);
		out_word_t res;
		logic [CNT_W-1:0] target;
		res = '0;
		if (w.req_type == REQ_READ) begin
			if (wr_ptr != rd_ptr) begin
				res.read_byte = ring[rd_ptr];
				res.read_valid = 1'b1;
				rd_ptr = rd_ptr + 1'b1;
			end
		end else begin
			if (!rx_busy) begin
				if (last_level && !w.rx_level) begin
					rx_busy = 1'b1;
					tick_cnt = '0;
					bit_pos = '0;
					shift_reg = '0;
					led_q = ~led_q;
				end
			end else begin
				// The first sample waits one and a half bit times, later ones a full bit.
				target = CNT_W'(CNT_W'(half_ticks) * ((bit_pos == 3'd0) ? 3 : 2));
				tick_cnt = tick_cnt + 1'b1;
				if (tick_cnt >= target) begin
					tick_cnt = '0;
					if (w.rx_level)
						shift_reg[bit_pos] = 1'b1;
					if (bit_pos == 3'd7) begin
						opamp_q = (shift_reg == match_byte);
						// No full check: an overrun overwrites unread bytes.
						ring[wr_ptr] = shift_reg;
						wr_ptr = wr_ptr + 1'b1;
						rx_busy = 1'b0;
						bit_pos = '0;
						res.byte_stored = 1'b1;
					end else begin
						bit_pos = bit_pos + 1'b1;
					end
				end
			end
			last_level = w.rx_level;
		end
		res.available = (wr_ptr != rd_ptr);
		res.opamp_level = opamp_q;
		res.led_level = led_q;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_ticks = HALF_BIT_TICKS_RST;
			match_byte = SELECT_BYTE_RST;
			rx_busy = 1'b0;
			tick_cnt = '0;
			bit_pos = '0;
			shift_reg = '0;
			last_level = 1'b1;
			wr_ptr = '0;
			rd_ptr = '0;
			opamp_q = 1'b0;
			led_q = 1'b0;
			expected_words.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (wr_en) begin
				if (wr_index == REG_HALF_BIT_TICKS)
					half_ticks = wr_data;
				else if (wr_index == REG_SELECT_BYTE)
					match_byte = wr_data[BYTE_W-1:0];
			end
			if (in_valid && !in_stall)
				expected_words.push_back(predict_uart_word(in_data));
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result word %h at %0t", out_data, $realtime);
				end else begin
					want_word = expected_words.pop_front();
					if (out_data.read_byte !== want_word.read_byte
							|| out_data.read_valid !== want_word.read_valid
							|| out_data.available !== want_word.available
							|| out_data.byte_stored !== want_word.byte_stored
							|| out_data.opamp_level !== want_word.opamp_level
							|| out_data.led_level !== want_word.led_level) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display({"word mismatch at %0t: expected byte=%02h valid=%b",
								" avail=%b stored=%b opamp=%b led=%b, got byte=%02h",
								" valid=%b avail=%b stored=%b opamp=%b led=%b"},
								$realtime, want_word.read_byte, want_word.read_valid,
								want_word.available, want_word.byte_stored,
								want_word.opamp_level, want_word.led_level,
								out_data.read_byte, out_data.read_valid, out_data.available,
								out_data.byte_stored, out_data.opamp_level, out_data.led_level);
					end
				end
			end
			pending = expected_words.size();
		end
	end

endmodule

FILE: tb/tb_uart_rx_sampler_with_ring_buffer.sv
// Testbench top that drives serial frames and buffer reads into the UART receiver block.
module tb_uart_rx_sampler_with_ring_buffer;
	import urxrb_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	in_word_t          in_data;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_word_t         out_data;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_index;
	logic [HALF_W-1:0] wr_data;

	int mismatches;
	int pending;
	int idle_pct = 0;
	int stall_pct = 0;
	int read_pct = 0;
	int budget = 0;
	int cur_half = 0;
	int quiet_cycles = 0;

	uart_rx_sampler_with_ring_buffer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	uart_rx_result_checker result_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// A run is stuck when neither channel moves a word for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_uart_rx_sampler_with_ring_buffer: errors");
				$finish;
			end
		end
	end

	task automatic send_item(logic req, logic lvl);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data <= '{req_type: req, rx_level: lvl};
		in_valid <= 1'b1;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		if (budget > 0)
			budget--;
	endtask

	// One line sample, sometimes preceded by a read that takes no line time.
	task automatic line_tick(logic lvl);
		if ($urandom_range(0, 99) < read_pct)
			send_item(REQ_READ, 1'($urandom_range(0, 1)));
		send_item(REQ_TICK, lvl);
	endtask

	task automatic hold_level(logic lvl, int n);
		for (int k = 0; k < n && budget > 0; k++)
			line_tick(lvl);
	endtask

	task automatic send_frame(logic [BYTE_W-1:0] value);
		hold_level(1'b1, 1);
		if (cur_half == 0) begin
			hold_level(1'b0, 1);
			for (int i = 0; i < BYTE_W; i++)
				hold_level(value[i], 1);
			hold_level(1'b1, $urandom_range(1, 3));
		end else begin
			hold_level(1'b0, 2 * cur_half);
			for (int i = 0; i < BYTE_W; i++)
				hold_level(value[i], 2 * cur_half);
			hold_level(1'b1, 2 * cur_half + $urandom_range(0, 3));
		end
	endtask

	task automatic set_config(logic [HALF_W-1:0] half, logic [BYTE_W-1:0] sel);
		wr_en <= 1'b1;
		wr_index <= REG_HALF_BIT_TICKS;
		wr_data <= half;
		@(posedge clk);
		wr_index <= REG_SELECT_BYTE;
		wr_data <= HALF_W'(sel);
		@(posedge clk);
		wr_en <= 1'b0;
		cur_half = int'(half);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(int half, logic [BYTE_W-1:0] sel, int n, int rd, int noise,
			int idle, int stall);
		set_config(half[HALF_W-1:0], sel);
		read_pct = rd;
		idle_pct = idle;
		stall_pct = stall;
		budget = n;
		while (budget > 0) begin
			if ($urandom_range(0, 99) < noise)
				repeat ($urandom_range(1, 6)) hold_level(1'($urandom_range(0, 1)), 1);
			else if ($urandom_range(0, 3) == 0)
				send_frame(sel);
			else
				send_frame(BYTE_W'($urandom_range(0, 255)));
		end
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero half-bit time samples on every tick after the start edge.
		set_config('0, 8'hFF);
		budget = 1000;
		send_item(REQ_READ, 1'b0);
		send_item(REQ_READ, 1'b1);
		line_tick(1'b1);
		line_tick(1'b0);
		repeat (3) line_tick(1'b1);
		send_item(REQ_READ, 1'b0);
		repeat (5) line_tick(1'b1);
		// Second word has falling edges inside the byte, which must not restart it.
		line_tick(1'b0);
		line_tick(1'b1);
		line_tick(1'b0);
		line_tick(1'b1);
		repeat (5) line_tick(1'b0);
		repeat (3) send_item(REQ_READ, 1'b0);
		settle();

		run_phase(1, BYTE_W'($urandom_range(0, 255)), 80, 10, 5, 0, 0);
		run_phase(2, 8'h00, 70, 10, 5, 48, 0);
		// Few reads against many short frames so the ring buffer overruns.
		run_phase(0, 8'hFF, 260, 1, 3, 0, 48);
		// Longest bit time: only the start of a byte fits, the next phase finishes it.
		run_phase(65535, BYTE_W'($urandom_range(0, 255)), 40, 30, 0, 38, 38);
		run_phase(3, BYTE_W'($urandom_range(0, 255)), 70, 15, 8, 38, 38);

		repeat (6) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb_uart_rx_sampler_with_ring_buffer: clean");
		else
			$display("tb_uart_rx_sampler_with_ring_buffer: errors");
		$finish;
	end

endmodule

FILE: uart_rx_sampler_with_ring_buffer.f
+incdir+sv
sv/urxrb_pkg.sv
sv/urxrb_ram.sv
sv/urxrb_rx.sv
sv/urxrb_fifo.sv
sv/uart_rx_sampler_with_ring_buffer.sv
sv/urxrb_checker.sv
tb/uart_rx_result_checker.sv
tb/tb_uart_rx_sampler_with_ring_buffer.sv
